// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i and idle in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The condition must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== sv/rdq_pkg.sv =====
// ----------------------------------------------------------------------------
// Reversible deque package
// Payload types, command and status codes, and controller/datapath types.
// ----------------------------------------------------------------------------
package rdq_pkg;

  localparam int unsigned CAPACITY_DEF = 64;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned VALUE_W  = 31;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;

  // Command codes carried in the request.
  localparam logic [CMD_W-1:0] CMD_ADD_FRONT  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD_BACK   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DROP_FRONT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REVERSE    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ_OUT   = 3'd5;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STS_ELEM  = 2'd2;
  localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  element;
    logic [COUNT_W-1:0]  count;
    logic                last;
  } out_item_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_ADD_FRONT,
    DP_ADD_BACK,
    DP_DROP_FRONT,
    DP_REVERSE,
    DP_WALK_START,
    DP_RM_STEP,
    DP_RD_STEP,
    DP_RM_COMMIT
  } dp_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RM_WALK,
    ST_RM_END,
    ST_RD_WALK
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e              op;
    logic                out_load;
    logic [STATUS_W-1:0] out_status;
    logic                out_elem;
    logic                out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic more;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== sv/reversible_deque_with_value_purge_core.sv =====
// ----------------------------------------------------------------------------
// Reversible deque with value purge
// Bounded double-ended queue with front/back insert, front drop, removal of
// all copies of a value, order reversal and full read-out.
// ----------------------------------------------------------------------------
//   Channel | Direction | Handshake               | Payload
//   in      | request   | in_valid_i / in_stall_o  | in_item_t  (cmd, value)
//   out     | result    | out_valid_o / out_stall_i| out_item_t (status, element,
//           |           |                          |   count, last)
//
// Insert, drop, reverse and unused codes give one result each.
// Value removal walks the store through the single memory read port.
// Read-out gives one element per cycle while no result is stalled.
// Reset clears front, count and direction; memory content needs no clearing.
// A stalled result holds back the next request, each read-out element and
// the final result of a removal; the removal walk itself never waits.
// ----------------------------------------------------------------------------
module reversible_deque_with_value_purge_core import rdq_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  rdq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_data_i.cmd),
    .in_stall_o (in_stall_o),
    .cmd_o      (dp_cmd),
    .sts_i      (dp_sts)
  );

  rdq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .value_i     (in_data_i.value),
    .sts_o       (dp_sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== sv/rdq_dp.sv =====
// ----------------------------------------------------------------------------
// Reversible deque datapath
// Circular element memory, front/count/direction registers, walk pointers
// and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rdq_dp import rdq_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  dp_cmd_t   cmd_i,
  input  logic [VALUE_W-1:0] value_i,
  output dp_sts_t   sts_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int unsigned PtrW  = $clog2(CAPACITY);
  localparam int unsigned PtrW1 = PtrW + 1;
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam logic [PtrW-1:0]  LastSlot = PtrW'(CAPACITY - 1);
  localparam logic [PtrW1-1:0] CapWide  = PtrW1'(CAPACITY);
  localparam logic [CntW-1:0]  CapCnt   = CntW'(CAPACITY);
  localparam logic [CntW-1:0]  OneCnt   = CntW'(1);

  // Neighbor slot, moving down or up with wrap.
  function automatic logic [PtrW-1:0] step_ptr(input logic [PtrW-1:0] p, input logic down);
    logic [PtrW-1:0] r;
    if (down) begin
      r = (p == '0) ? LastSlot : p - 1'b1;
    end else begin
      r = (p == LastSlot) ? '0 : p + 1'b1;
    end
    return r;
  endfunction

  // Slot k places from p, moving down or up with wrap; k is below the capacity.
  function automatic logic [PtrW-1:0] offset_ptr(input logic [PtrW-1:0] p,
                                                 input logic [PtrW-1:0] k,
                                                 input logic down);
    logic [PtrW1-1:0] s;
    if (down) begin
      if (p >= k) begin
        s = {1'b0, p} - {1'b0, k};
      end else begin
        s = {1'b0, p} + CapWide - {1'b0, k};
      end
    end else begin
      s = {1'b0, p} + {1'b0, k};
      if (s >= CapWide) begin
        s = s - CapWide;
      end
    end
    return s[PtrW-1:0];
  endfunction

  logic [VALUE_W-1:0] mem_q [CAPACITY];
  logic [VALUE_W-1:0] rdata_q;

  logic [PtrW-1:0]    front_q, front_d;
  logic [CntW-1:0]    count_q, count_d;
  logic               rev_q, rev_d;
  logic [PtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [CntW-1:0]    issued_q, issued_d;
  logic [CntW-1:0]    kept_q, kept_d;
  logic [VALUE_W-1:0] val_q, val_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_data_q, out_data_d;

  logic               mem_we, mem_re;
  logic [PtrW-1:0]    mem_waddr, mem_raddr;
  logic [VALUE_W-1:0] mem_wdata;

  logic               add_live;
  logic               commit_op;

  assign sts_o.empty    = (count_q == '0);
  assign sts_o.full     = (count_q >= CapCnt);
  assign sts_o.more     = (issued_q != count_q);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    front_d   = front_q;
    count_d   = count_q;
    rev_d     = rev_q;
    rd_ptr_d  = rd_ptr_q;
    wr_ptr_d  = wr_ptr_q;
    issued_d  = issued_q;
    kept_d    = kept_q;
    val_d     = val_q;
    mem_we    = 1'b0;
    mem_waddr = front_q;
    mem_wdata = value_i;
    mem_re    = 1'b0;
    mem_raddr = rd_ptr_q;
    unique case (cmd_i.op)
      DP_NOP: begin
      end
      DP_ADD_FRONT: begin
        // The front moves against the direction in which the sequence runs.
        if (count_q != '0) begin
          front_d = step_ptr(front_q, !rev_q);
        end
        mem_we    = 1'b1;
        mem_waddr = front_d;
        count_d   = count_q + 1'b1;
      end
      DP_ADD_BACK: begin
        mem_we    = 1'b1;
        mem_waddr = offset_ptr(front_q, PtrW'(count_q), rev_q);
        count_d   = count_q + 1'b1;
      end
      DP_DROP_FRONT: begin
        if (count_q != '0) begin
          count_d = count_q - 1'b1;
          if (count_q > OneCnt) begin
            front_d = step_ptr(front_q, rev_q);
          end
        end
      end
      DP_REVERSE: begin
        if (count_q > OneCnt) begin
          front_d = offset_ptr(front_q, PtrW'(count_q - 1'b1), rev_q);
          rev_d   = !rev_q;
        end
      end
      DP_WALK_START: begin
        mem_re    = 1'b1;
        mem_raddr = front_q;
        rd_ptr_d  = step_ptr(front_q, rev_q);
        wr_ptr_d  = front_q;
        issued_d  = OneCnt;
        kept_d    = '0;
        val_d     = value_i;
      end
      DP_RM_STEP: begin
        // Survivors are packed toward the front; the write slot never passes
        // the slot being read ahead.
        if (rdata_q != val_q) begin
          mem_we    = 1'b1;
          mem_waddr = wr_ptr_q;
          mem_wdata = rdata_q;
          wr_ptr_d  = step_ptr(wr_ptr_q, rev_q);
          kept_d    = kept_q + 1'b1;
        end
        if (issued_q != count_q) begin
          mem_re   = 1'b1;
          rd_ptr_d = step_ptr(rd_ptr_q, rev_q);
          issued_d = issued_q + 1'b1;
        end
      end
      DP_RD_STEP: begin
        if (issued_q != count_q) begin
          mem_re   = 1'b1;
          rd_ptr_d = step_ptr(rd_ptr_q, rev_q);
          issued_d = issued_q + 1'b1;
        end
      end
      DP_RM_COMMIT: begin
        count_d = kept_q;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = cmd_i.out_load || (out_valid_q && out_stall_i);
    out_data_d  = out_data_q;
    if (cmd_i.out_load) begin
      out_data_d.status  = cmd_i.out_status;
      out_data_d.element = cmd_i.out_elem ? rdata_q : '0;
      out_data_d.count   = COUNT_W'(count_d);
      out_data_d.last    = cmd_i.out_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      count_q     <= '0;
      rev_q       <= 1'b0;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      issued_q    <= '0;
      kept_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      front_q     <= front_d;
      count_q     <= count_d;
      rev_q       <= rev_d;
      rd_ptr_q    <= rd_ptr_d;
      wr_ptr_q    <= wr_ptr_d;
      issued_q    <= issued_d;
      kept_q      <= kept_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q      <= val_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign add_live  = (cmd_i.op == DP_ADD_FRONT || cmd_i.op == DP_ADD_BACK) && !sts_o.full;
  assign commit_op = (cmd_i.op == DP_RM_COMMIT);

  `ASSERT_ALWAYS(a_add_grows, add_live |=> (count_q == $past(count_q) + 1'b1), "insert miscount")
  `ASSERT_ALWAYS(a_purge_shrinks, commit_op |=> (count_q <= $past(count_q)), "purge grew the store")

endmodule

// ===== sv/rdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Reversible deque controller
// Request decode and sequencing of removal and read-out walks.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rdq_ctrl import rdq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [CMD_W-1:0] in_cmd_i,
  output logic             in_stall_o,
  output dp_cmd_t          cmd_o,
  input  dp_sts_t          sts_i
);

  ctrl_state_e state_q, state_d;
  logic        accept;

  assign in_stall_o = !((state_q == ST_IDLE) && sts_i.out_free);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d          = state_q;
    cmd_o.op         = DP_NOP;
    cmd_o.out_load   = 1'b0;
    cmd_o.out_status = STS_DONE;
    cmd_o.out_elem   = 1'b0;
    cmd_o.out_last   = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_cmd_i)
            CMD_ADD_FRONT: begin
              cmd_o.op         = sts_i.full ? DP_NOP : DP_ADD_FRONT;
              cmd_o.out_load   = 1'b1;
              cmd_o.out_status = sts_i.full ? STS_FULL : STS_DONE;
            end
            CMD_ADD_BACK: begin
              cmd_o.op         = sts_i.full ? DP_NOP : DP_ADD_BACK;
              cmd_o.out_load   = 1'b1;
              cmd_o.out_status = sts_i.full ? STS_FULL : STS_DONE;
            end
            CMD_DROP_FRONT: begin
              cmd_o.op       = DP_DROP_FRONT;
              cmd_o.out_load = 1'b1;
            end
            CMD_REVERSE: begin
              cmd_o.op       = DP_REVERSE;
              cmd_o.out_load = 1'b1;
            end
            CMD_REMOVE: begin
              if (sts_i.empty) begin
                cmd_o.out_load = 1'b1;
              end else begin
                cmd_o.op = DP_WALK_START;
                state_d  = ST_RM_WALK;
              end
            end
            CMD_READ_OUT: begin
              if (sts_i.empty) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_status = STS_EMPTY;
              end else begin
                cmd_o.op = DP_WALK_START;
                state_d  = ST_RD_WALK;
              end
            end
            default: begin
              cmd_o.out_load = 1'b1;
            end
          endcase
        end
      end
      ST_RM_WALK: begin
        cmd_o.op = DP_RM_STEP;
        if (!sts_i.more) begin
          state_d = ST_RM_END;
        end
      end
      ST_RM_END: begin
        if (sts_i.out_free) begin
          cmd_o.op       = DP_RM_COMMIT;
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_RD_WALK: begin
        // The held read data goes out while the next element is fetched.
        if (sts_i.out_free) begin
          cmd_o.op         = DP_RD_STEP;
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = STS_ELEM;
          cmd_o.out_elem   = 1'b1;
          cmd_o.out_last   = !sts_i.more;
          if (!sts_i.more) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `ASSERT_ALWAYS(a_no_overwrite, cmd_o.out_load |-> sts_i.out_free, "result register overwritten while a result waits")
  `ASSERT_ALWAYS(a_walk_nonempty, (state_q == ST_RD_WALK || state_q == ST_RM_WALK) |-> !sts_i.empty, "element walk on an empty store")

endmodule

// ===== dv/reversible_deque_with_value_purge_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Reversible deque with value purge: block-level test
// Drives front/back inserts, front drops, value purges, reversals, read-outs
// and the unused command codes through the request channel. A mirror of the
// deque predicts every result, and each accepted result is checked field by
// field. Both sides idle at random; one long result stall backs up the requests.
// ----------------------------------------------------------------------------
module reversible_deque_with_value_purge_core_test import rdq_pkg::*; ();

  localparam int CLK_PERIOD      = 20;
  localparam int RESET_CYCLES    = 11;
  localparam int DEPTH           = CAPACITY_DEF;
  localparam int RANDOM_REQUESTS = 130;
  localparam int CALM_TAIL       = 40;
  localparam int LONG_HOLD       = 400;
  // A purge walks the whole store; leave room for a full one.
  localparam int SETTLE_CYCLES   = 2 * DEPTH + 16;
  localparam int TIMEOUT_CYCLES  = 2_000_000;
  localparam int REPORT_LIMIT    = 10;

  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
  localparam logic [VALUE_W-1:0] VALUE_MAX  = {VALUE_W{1'b1}};

  // Mirror of the deque contents plus the results it still owes.
  class deque_mirror;
    logic [VALUE_W-1:0] elems[$];
    out_item_t          owed_results[$];
    int                 capacity;
    int                 mismatches;
    int                 requests;
    int                 results;
    int                 readouts;
    int                 dropped_inserts;
    int                 peak;

    function new(int cap);
      capacity = cap;
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    function void owe(logic [STATUS_W-1:0] status, logic [VALUE_W-1:0] element,
                      logic last);
      out_item_t r;
      r.status  = status;
      r.element = element;
      r.count   = COUNT_W'(elems.size());
      r.last    = last;
      owed_results.push_back(r);
    endfunction

    function void apply_request(in_item_t req);
      logic [VALUE_W-1:0]  kept[$];
      logic [STATUS_W-1:0] status;
      status = STS_DONE;
      requests++;
      case (req.cmd)
        CMD_ADD_FRONT, CMD_ADD_BACK: begin
          if (elems.size() >= capacity) begin
            status = STS_FULL;
            dropped_inserts++;
          end else if (req.cmd == CMD_ADD_FRONT) begin
            elems.push_front(req.value);
          end else begin
            elems.push_back(req.value);
          end
        end
        CMD_DROP_FRONT: begin
          if (elems.size() > 0) void'(elems.pop_front());
        end
        CMD_REMOVE: begin
          foreach (elems[i]) if (elems[i] != req.value) kept.push_back(elems[i]);
          elems = kept;
        end
        CMD_REVERSE: begin
          foreach (elems[i]) kept.push_front(elems[i]);
          elems = kept;
        end
        CMD_READ_OUT: begin
          readouts++;
          if (elems.size() == 0) begin
            owe(STS_EMPTY, '0, 1'b1);
          end else begin
            foreach (elems[i]) owe(STS_ELEM, elems[i], i == elems.size() - 1);
          end
          return;
        end
        default: ;
      endcase
      if (elems.size() > peak) peak = elems.size();
      owe(status, '0, 1'b1);
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("%s", msg);
    endfunction

    function void compare_result(out_item_t got);
      out_item_t want;
      results++;
      if (owed_results.size() == 0) begin
        flag($sformatf("unexpected result: status %0d element %h count %0d last %0b",
                       got.status, got.element, got.count, got.last));
        return;
      end
      want = owed_results.pop_front();
      if (got.status !== want.status || got.element !== want.element ||
          got.count !== want.count || got.last !== want.last) begin
        flag($sformatf({"result mismatch: expected status %0d element %h count %0d ",
                        "last %0b, got status %0d element %h count %0d last %0b"},
                       want.status, want.element, want.count, want.last,
                       got.status, got.element, got.count, got.last));
      end
    endfunction
  endclass

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  deque_mirror mirror = new(DEPTH);

  bit tx_idling    = 1'b1;
  bit rx_idling    = 1'b1;
  bit hold_request = 1'b0;

  reversible_deque_with_value_purge_core #(
    .CAPACITY(DEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // The request is noted first, then an accepted result is checked against
  // the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) mirror.apply_request(in_data);
      if (out_valid && !out_stall) mirror.compare_result(out_data);
    end
  end

  // Result side: random stall bursts, or one long hold when asked.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_stall    <= 1'b0;
        hold_request = 1'b0;
      end else if (rx_idling && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("reversible_deque_with_value_purge_core_test: FAIL");
    $finish;
  end

  task automatic send_request(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] value);
    in_item_t req;
    req.cmd   = cmd;
    req.value = value;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk_i); while (in_stall);
    if (tx_idling && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (mirror.pending() != 0) @(posedge clk_i);
  endtask

  // Mostly a small pool so that purges find matches; sometimes near the top
  // of the range or anywhere.
  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned sel;
    logic [VALUE_W-1:0] v;
    sel = $urandom_range(0, 19);
    v   = VALUE_W'($urandom);
    if (sel < 14) v = VALUE_W'($urandom_range(0, 7));
    else if (sel < 17) v = VALUE_MAX - VALUE_W'($urandom_range(0, 3));
    return v;
  endfunction

  function automatic logic [CMD_W-1:0] pick_command();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) return CMD_ADD_FRONT;
    if (roll < 55) return CMD_ADD_BACK;
    if (roll < 65) return CMD_DROP_FRONT;
    if (roll < 73) return CMD_REMOVE;
    if (roll < 83) return CMD_REVERSE;
    if (roll < 95) return CMD_READ_OUT;
    return roll[0] ? CMD_SPARE_HI : CMD_SPARE_LO;
  endfunction

  function automatic logic [CMD_W-1:0] pick_insert();
    return $urandom_range(0, 1) ? CMD_ADD_FRONT : CMD_ADD_BACK;
  endfunction

  initial begin
    int sent;
    int burst;
    int unsigned roll;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Empty store: read-out, drop, purge and reverse all leave it alone.
    send_request(CMD_READ_OUT, '0);
    send_request(CMD_DROP_FRONT, '0);
    send_request(CMD_REMOVE, 31'd5);
    send_request(CMD_REVERSE, '0);
    send_request(CMD_ADD_BACK, VALUE_MAX);
    send_request(CMD_REVERSE, '0);
    send_request(CMD_ADD_FRONT, '0);
    send_request(CMD_ADD_BACK, 31'd5);
    send_request(CMD_ADD_FRONT, 31'd5);
    send_request(CMD_READ_OUT, '0);
    send_request(CMD_REVERSE, '0);
    send_request(CMD_READ_OUT, '0);
    // Inserts at both ends while the order is reversed.
    send_request(CMD_ADD_FRONT, 31'd9);
    send_request(CMD_ADD_BACK, 31'd5);
    send_request(CMD_REMOVE, 31'd5);
    send_request(CMD_REMOVE, 31'd12345);
    send_request(CMD_READ_OUT, '0);
    send_request(CMD_DROP_FRONT, '0);
    send_request(CMD_SPARE_LO, 31'd3);
    send_request(CMD_SPARE_HI, 31'h5555_5555);
    send_request(CMD_READ_OUT, '0);
    send_request(CMD_REMOVE, VALUE_MAX);
    send_request(CMD_REMOVE, '0);
    send_request(CMD_READ_OUT, '0);
    wait_for_results();

    // Fill past capacity behind one long result stall, then read it all.
    hold_request = 1'b1;
    repeat (DEPTH + 2) send_request(pick_insert(), pick_value());
    send_request(CMD_READ_OUT, '0);
    send_request(CMD_REVERSE, '0);
    send_request(CMD_READ_OUT, '0);
    for (int v = 0; v < 4; v++) send_request(CMD_REMOVE, VALUE_W'(v));
    wait_for_results();

    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      tx_idling = (sent < RANDOM_REQUESTS - CALM_TAIL);
      rx_idling = tx_idling;
      roll      = $urandom_range(0, 19);
      if (roll == 0) begin
        burst = $urandom_range(2, 16);
        repeat (burst) send_request(CMD_DROP_FRONT, pick_value());
      end else if (roll == 1) begin
        burst = $urandom_range(8, 40);
        repeat (burst) send_request(pick_insert(), pick_value());
      end else begin
        burst = 1;
        send_request(pick_command(), pick_value());
      end
      sent += burst;
    end
    send_request(CMD_READ_OUT, '0);

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mirror.pending() != 0) mirror.flag("expected results never arrived");

    $display("Covered %0d requests and %0d results, including %0d read-outs.",
             mirror.requests, mirror.results, mirror.readouts);
    $display("Inserts refused on a full store: %0d; peak occupancy %0d of %0d.",
             mirror.dropped_inserts, mirror.peak, DEPTH);
    if (mirror.mismatches == 0) begin
      $display("reversible_deque_with_value_purge_core_test: PASS");
    end else begin
      $display("Mismatches: %0d", mirror.mismatches);
      $display("reversible_deque_with_value_purge_core_test: FAIL");
    end
    $finish;
  end

endmodule
